// ===== hdl/reply_frame_checker_unit_macros.svh =====
// Assertion macros for the reply frame checker.
`ifndef REPLY_FRAME_CHECKER_UNIT_MACROS_SVH
`define REPLY_FRAME_CHECKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RFC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RFC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RFC_ASSERT(label, clk, rst_n, prop, msg)
`define RFC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== hdl/rfc_pkg.sv =====
// Shared types and constants for the reply frame checker.
`default_nettype none
package rfc_pkg;
  typedef enum logic [1:0] {PH_HELLO = 2'd0, PH_REPLY = 2'd1, PH_STOP = 2'd2} phase_e;
  typedef enum logic [1:0] {
    ST_ACK = 2'd0, ST_HELLO = 2'd1, ST_ABORT = 2'd2, ST_ERROR = 2'd3
  } status_e;
  localparam logic [0:0] CMD_BYTE = 1'b0;
  localparam logic [0:0] CMD_RESTART = 1'b1;
  localparam logic [15:0] KIND_HELLO = 16'd1;
  localparam logic [15:0] KIND_ACK = 16'd4;
  localparam logic [15:0] KIND_ABORT = 16'd5;
  localparam logic [5:0] HDR_LEN = 6'd48;
  localparam logic [5:0] HDR_CRC_LEN = 6'd44;
  localparam logic [15:0] ACK_BODY = 16'd8;
  localparam logic [15:0] ABORT_BODY = 16'd4;
  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [63:0] MAGIC = 64'h00314f50444e504f;

  typedef struct packed {
    logic [0:0]  cmd;
    logic [7:0]  rx_byte;
    logic [15:0] expect_seq;
    logic [31:0] expect_row;
    logic [31:0] expect_crc;
    logic [31:0] expect_pages;
  } beat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/reply_frame_checker_unit.sv =====
// Top level of the reply frame checker.
//  channel | handshake               | payload
//  in      | in_valid_i / in_stall_o | cmd, rx_byte, expect_*
//  out     | out_valid_o/out_stall_i | status, abort_reason
// One byte per cycle sustained while the output is not stalled; the per-byte CRC update in the back sets it.
// An accepted last byte passes the queue entry and then the back's result register before result valid;
// it waits longer only while a stalled output keeps beats waiting in the queue.
// Reset clears phase and frame state; the nonce store is written by HELLO.
// A stalled output holds the result while the queue absorbs two more beats.
`default_nettype none
module reply_frame_checker_unit import rfc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [0:0]  cmd_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [15:0] expect_seq_i,
  input  wire logic [31:0] expect_row_i,
  input  wire logic [31:0] expect_crc_i,
  input  wire logic [31:0] expect_pages_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [2:0]       abort_reason_o
);
  beat_t in_beat, push_beat, pop_beat;
  logic push, full, pop, avail;
  assign in_beat = '{cmd: cmd_i, rx_byte: rx_byte_i, expect_seq: expect_seq_i,
                     expect_row: expect_row_i, expect_crc: expect_crc_i,
                     expect_pages: expect_pages_i};
  rfc_front u_front (.clk_i, .rst_ni, .in_valid_i, .in_stall_o, .beat_i(in_beat),
    .q_full_i(full), .push_o(push), .push_beat_o(push_beat));
  rfc_queue u_queue (.clk_i, .rst_ni, .push_i(push), .push_beat_i(push_beat),
    .full_o(full), .pop_i(pop), .avail_o(avail), .pop_beat_i_o(pop_beat));
  rfc_back u_back (.clk_i, .rst_ni, .avail_i(avail), .beat_i(pop_beat), .pop_o(pop),
    .out_valid_o, .out_stall_i, .status_o, .abort_reason_o);
endmodule
`default_nettype wire

// ===== hdl/rfc_queue.sv =====
// Two-entry beat queue between the front and the back.
`default_nettype none
module rfc_queue import rfc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire beat_t push_beat_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       avail_o,
  output beat_t      pop_beat_i_o
);
  beat_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q == 2'd2;
  assign avail_o = cnt_q != 2'd0;
  assign pop_beat_i_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_beat_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/rfc_back.sv =====
// Frame checking engine: one beat per cycle unless a stalled result blocks the pop; one result register.
`default_nettype none
`include "reply_frame_checker_unit_macros.svh"
module rfc_back import rfc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  avail_i,
  input  wire beat_t beat_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output logic [1:0] status_o,
  output logic [2:0] abort_reason_o
);
  phase_e phase_q, phase_d;
  logic [5:0] idx_q, idx_d;
  logic [31:0] hcrc_q, hcrc_d, bcrc_q, bcrc_d, reason_q, reason_d;
  logic [15:0] kind_q, kind_d, size_q, size_d;
  logic [31:0] hbody_q, hbody_d;
  logic mf_hdr_q, mf_hdr_d, mf_nz_q, mf_nz_d, mf_echo_q, mf_echo_d;
  logic [7:0] nonce_q [16];
  logic ov_q;
  logic [1:0] ost_q;
  logic [2:0] orsn_q;
  logic emit, nonce_we;
  logic [1:0] est;
  logic [2:0] ersn;
  phase_e enext;

  // accept a beat while the result slot is free or draining
  assign pop_o = avail_i && (!ov_q || !out_stall_i);
  assign out_valid_o = ov_q;
  assign status_o = ost_q;
  assign abort_reason_o = orsn_q;

  always_comb begin
    logic bad, hello, fhdr, fnz, fecho;
    logic [7:0] b;
    logic [5:0] i;
    logic [2:0] j;
    logic [31:0] fin, bfin;
    logic [15:0] k, s;
    logic [31:0] hb;
    b = beat_i.rx_byte;
    i = idx_q;
    j = 3'(i - HDR_LEN);
    hello = phase_q == PH_HELLO;
    phase_d = phase_q; idx_d = idx_q; hcrc_d = hcrc_q; bcrc_d = bcrc_q;
    kind_d = kind_q; size_d = size_q; hbody_d = hbody_q; reason_d = reason_q;
    mf_hdr_d = mf_hdr_q; mf_nz_d = mf_nz_q; mf_echo_d = mf_echo_q;
    emit = 1'b0; est = ST_ACK; ersn = 3'd0; enext = phase_q; nonce_we = 1'b0;
    bad = 1'b0;
    fhdr = 1'b0; fnz = 1'b0; fecho = 1'b0; bfin = '0; k = '0; s = '0; hb = '0;
    fin = hcrc_q ^ 32'hffffffff;
    if (!pop_o) begin
      // hold
    end else if (beat_i.cmd == CMD_RESTART) begin
      phase_d = PH_HELLO; enext = PH_HELLO; emit = 1'b0;
      idx_d = '0; hcrc_d = '1; bcrc_d = '1; kind_d = '0; size_d = '0; hbody_d = '0;
      reason_d = '0; mf_hdr_d = 1'b0; mf_nz_d = 1'b0; mf_echo_d = 1'b0;
    end else if (phase_q == PH_HELLO || phase_q == PH_REPLY) begin
      if (i < HDR_LEN) begin
        if (i < HDR_CRC_LEN) hcrc_d = crc_byte(hcrc_q, b);
        if (i < 6'd8) bad = b != MAGIC[i[2:0]*8 +: 8];
        else if (i == 6'd8) bad = b != 8'd1;
        else if (i == 6'd10) kind_d[7:0] = b;
        else if (i == 6'd11) kind_d[15:8] = b;
        else if (i == 6'd12) bad = b != 8'd48;
        else if (i < 6'd16) bad = b != 8'd0;
        else if (i < 6'd32) begin
          if (hello) begin
            nonce_we = 1'b1;
            if (b != 8'd0) mf_nz_d = 1'b1;
          end else bad = b != nonce_q[i[3:0]];
        end else if (i < 6'd34)
          bad = b != (hello ? 8'hff : beat_i.expect_seq[i[0]*8 +: 8]);
        else if (i < 6'd36) size_d[i[0]*8 +: 8] = b;
        else if (i < 6'd40)
          bad = b != (hello ? 8'hff : beat_i.expect_row[i[1:0]*8 +: 8]);
        else if (i < 6'd44) hbody_d[i[1:0]*8 +: 8] = b;
        else bad = b != fin[i[1:0]*8 +: 8];
        fhdr = mf_hdr_q | bad;
        mf_hdr_d = fhdr;
        fnz = mf_nz_d;
        k = kind_d; s = size_d; hb = hbody_d;
        if (i != HDR_LEN - 6'd1) idx_d = i + 6'd1;
        else if (hello) begin
          emit = 1'b1;
          if (fhdr || k != KIND_HELLO || s != 16'd0 || hb != 32'd0 || !fnz) begin
            est = ST_ERROR; enext = PH_STOP;
          end else begin
            est = ST_HELLO; enext = PH_REPLY;
          end
        end else if (fhdr || !((k == KIND_ACK && s == ACK_BODY) ||
                               (k == KIND_ABORT && s == ABORT_BODY))) begin
          emit = 1'b1; est = ST_ERROR; enext = PH_STOP;
        end else idx_d = HDR_LEN;
      end else begin
        bcrc_d = crc_byte(bcrc_q, b);
        fecho = mf_echo_q;
        if (j < 3'd4) begin
          reason_d[j[1:0]*8 +: 8] = b;
          if (b != beat_i.expect_crc[j[1:0]*8 +: 8]) fecho = 1'b1;
        end else if (b != beat_i.expect_pages[j[1:0]*8 +: 8]) fecho = 1'b1;
        mf_echo_d = fecho;
        bfin = bcrc_d ^ 32'hffffffff;
        if ({13'd0, j} + 16'd1 < size_q && j != 3'd7) idx_d = i + 6'd1;
        else begin
          emit = 1'b1; est = ST_ERROR; enext = PH_STOP;
          if (bfin != hbody_q) est = ST_ERROR;
          else if (kind_q == KIND_ABORT) begin
            if (reason_d >= 32'd1 && reason_d <= 32'd4) begin
              est = ST_ABORT; ersn = reason_d[2:0];
            end
          end else if (!fecho) begin
            est = ST_ACK; enext = PH_REPLY;
          end
        end
      end
      if (emit) begin
        phase_d = enext;
        idx_d = '0; hcrc_d = '1; bcrc_d = '1; kind_d = '0; size_d = '0; hbody_d = '0;
        reason_d = '0; mf_hdr_d = 1'b0; mf_nz_d = 1'b0; mf_echo_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (nonce_we) nonce_q[idx_q[3:0]] <= beat_i.rx_byte;
    if (emit) begin
      ost_q <= est;
      orsn_q <= ersn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HELLO; idx_q <= '0; hcrc_q <= '1; bcrc_q <= '1;
      kind_q <= '0; size_q <= '0; hbody_q <= '0; reason_q <= '0;
      mf_hdr_q <= 1'b0; mf_nz_q <= 1'b0; mf_echo_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d; idx_q <= idx_d; hcrc_q <= hcrc_d; bcrc_q <= bcrc_d;
      kind_q <= kind_d; size_q <= size_d; hbody_q <= hbody_d; reason_q <= reason_d;
      mf_hdr_q <= mf_hdr_d; mf_nz_q <= mf_nz_d; mf_echo_q <= mf_echo_d;
      if (emit) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  `RFC_ASSERT(a_idx_range, clk_i, rst_ni, idx_q <= HDR_LEN + 6'd7, "byte index overran")
  `RFC_ASSERT(a_stop_idle, clk_i, rst_ni, (phase_q == PH_STOP) |-> (idx_q == 6'd0), "stopped mid frame")
  `RFC_ASSERT(a_reason, clk_i, rst_ni, (ov_q && ost_q != ST_ABORT) |-> (orsn_q == 3'd0), "stray reason")
  `RFC_ASSERT(a_hold, clk_i, rst_ni, (ov_q && out_stall_i) |=> (ov_q && $stable(ost_q)), "result lost")
endmodule
`default_nettype wire

// ===== hdl/rfc_front.sv =====
// Input stage: passes beats to the queue, stalls when it is full, and zeroes the byte of restarts.
`default_nettype none
`include "reply_frame_checker_unit_macros.svh"
module rfc_front import rfc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire beat_t beat_i,
  input  wire logic  q_full_i,
  output logic       push_o,
  output beat_t      push_beat_o
);
  assign in_stall_o = q_full_i;
  assign push_o = in_valid_i && !q_full_i;
  // restart beats carry no byte; zero it so the queue holds a clean word
  always_comb begin
    push_beat_o = beat_i;
    if (beat_i.cmd == CMD_RESTART) push_beat_o.rx_byte = 8'd0;
  end
  `RFC_ASSERT(a_no_push_full, clk_i, rst_ni, q_full_i |-> !push_o, "push into full queue")
endmodule
`default_nettype wire

// ===== verif/reply_frame_checker_unit_test.sv =====
// Testbench for the reply frame checker: directed and random frames against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module reply_frame_checker_unit_test;
  import rfc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [0:0]  cmd_i = CMD_BYTE;
  logic [7:0]  rx_byte_i = '0;
  logic [15:0] expect_seq_i = '0;
  logic [31:0] expect_row_i = '0;
  logic [31:0] expect_crc_i = '0;
  logic [31:0] expect_pages_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [2:0]  abort_reason_o;

  reply_frame_checker_unit dut (.*);

  always #1 clk_i = ~clk_i;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] reason;
  } verdict_t;

  // predictor state
  phase_e      pr_phase;
  logic [5:0]  pr_idx;
  logic [7:0]  pr_nonce [16];
  logic [31:0] pr_hcrc, pr_bcrc, pr_reason;
  logic [63:0] pr_fields;
  logic        pr_hdr_bad, pr_nz, pr_echo_bad;

  verdict_t verdicts_due[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  hold_rx = 1'b0;
  bit  hold_busy = 1'b0;
  bit  session_live = 1'b0;   // a HELLO has been accepted since last restart and no abort, fault or junk followed
  logic [7:0] sess_nonce [16];
  logic [15:0] cur_seq;
  logic [31:0] cur_row, cur_crc, cur_pages;
  int  results_seen = 0;

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'hedb88320) : (r >> 1);
    return r;
  endfunction

  function automatic void clear_frame();
    pr_idx = '0; pr_hcrc = '1; pr_bcrc = '1; pr_fields = '0;
    pr_hdr_bad = 0; pr_nz = 0; pr_echo_bad = 0; pr_reason = '0;
  endfunction

  function automatic void finish_frame(input status_e st, input logic [2:0] rs,
                                       input phase_e nxt);
    verdict_t v;
    v.status = st; v.reason = rs;
    verdicts_due.push_back(v);
    pr_phase = nxt;
    clear_frame();
  endfunction

  // models one accepted beat
  function automatic void predict_beat(input logic c, input logic [7:0] b,
      input logic [15:0] seq_in, input logic [31:0] row_in,
      input logic [31:0] ecrc, input logic [31:0] epg);
    int i, j;
    logic hello;
    logic [15:0] kind, size, seq;
    logic [31:0] row, fin;
    if (c == CMD_RESTART) begin
      pr_phase = PH_HELLO; clear_frame(); return;
    end
    if (pr_phase != PH_HELLO && pr_phase != PH_REPLY) return;
    i = pr_idx;
    hello = (pr_phase == PH_HELLO);
    seq = hello ? 16'hffff : seq_in;
    row = hello ? 32'hffffffff : row_in;
    if (i < 48) begin
      if (i < 44) pr_hcrc = crc_step(pr_hcrc, b);
      if (i < 8) pr_hdr_bad |= b != MAGIC[i*8 +: 8];
      else if (i == 8) pr_hdr_bad |= b != 8'd1;
      else if (i == 10 || i == 11) pr_fields[(i-10)*8 +: 8] = b;
      else if (i == 12) pr_hdr_bad |= b != 8'd48;
      else if (i == 9 || (i >= 13 && i <= 15)) pr_hdr_bad |= b != 8'd0;
      else if (i < 32) begin
        if (hello) begin
          pr_nonce[i-16] = b;
          if (b != 0) pr_nz = 1;
        end else pr_hdr_bad |= b != pr_nonce[i-16];
      end else if (i < 34) pr_hdr_bad |= b != seq[(i-32)*8 +: 8];
      else if (i < 36) pr_fields[16 + (i-34)*8 +: 8] = b;
      else if (i < 40) pr_hdr_bad |= b != row[(i-36)*8 +: 8];
      else if (i < 44) pr_fields[32 + (i-40)*8 +: 8] = b;
      else begin
        fin = ~pr_hcrc;
        pr_hdr_bad |= b != fin[(i-44)*8 +: 8];
      end
      if (i < 47) begin
        pr_idx = 6'(i + 1); return;
      end
      kind = pr_fields[15:0]; size = pr_fields[31:16];
      if (hello) begin
        if (pr_hdr_bad || kind != KIND_HELLO || size != 0 || pr_fields[63:32] != 0 || !pr_nz)
          finish_frame(ST_ERROR, 3'd0, PH_STOP);
        else finish_frame(ST_HELLO, 3'd0, PH_REPLY);
        return;
      end
      if (pr_hdr_bad || !((kind == KIND_ACK && size == ACK_BODY) ||
                          (kind == KIND_ABORT && size == ABORT_BODY)))
        finish_frame(ST_ERROR, 3'd0, PH_STOP);
      else pr_idx = HDR_LEN;
      return;
    end
    kind = pr_fields[15:0]; size = pr_fields[31:16];
    j = i - 48;
    pr_bcrc = crc_step(pr_bcrc, b);
    if (j < 4) begin
      pr_reason[j*8 +: 8] = b;
      if (b != ecrc[j*8 +: 8]) pr_echo_bad = 1;
    end else if (j < 8) begin
      if (b != epg[(j-4)*8 +: 8]) pr_echo_bad = 1;
    end
    if (j + 1 < size && j + 1 < 8) begin
      pr_idx = 6'(i + 1); return;
    end
    if (~pr_bcrc != pr_fields[63:32]) finish_frame(ST_ERROR, 3'd0, PH_STOP);
    else if (kind == KIND_ABORT) begin
      if (pr_reason < 1 || pr_reason > 4) finish_frame(ST_ERROR, 3'd0, PH_STOP);
      else finish_frame(ST_ABORT, pr_reason[2:0], PH_STOP);
    end else if (pr_echo_bad) finish_frame(ST_ERROR, 3'd0, PH_STOP);
    else finish_frame(ST_ACK, 3'd0, PH_REPLY);
  endfunction

  // predictor, result checker and watchdog
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o)
      predict_beat(cmd_i, rx_byte_i, expect_seq_i, expect_row_i, expect_crc_i, expect_pages_i);
  end

  always @(posedge clk_i) begin
    verdict_t v;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result status=%0d reason=%0d", $time, status_o,
                 abort_reason_o);
        errors++;
      end else begin
        v = verdicts_due.pop_front();
        if (status_o !== v.status) begin
          $display("%0t: status expected %0d actual %0d", $time, v.status, status_o);
          errors++;
        end
        if (abort_reason_o !== v.reason) begin
          $display("%0t: abort_reason expected %0d actual %0d", $time, v.reason,
                   abort_reason_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver stall: random, lighter while draining, or held high for a long stretch on request
  always @(posedge clk_i) begin
    if (hold_rx) out_stall_i <= 1'b1;
    else if (hold_busy) out_stall_i <= ($urandom_range(0, 9) < 2);
    else out_stall_i <= ($urandom_range(0, 99) < 30) ? 1'b1 : 1'b0;
  end

  task automatic send_beat(input logic c, input logic [7:0] b);
    int g;
    g = gap_len();
    repeat (g) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c;
    rx_byte_i <= ($urandom_range(0, 1) && c == CMD_RESTART) ? 8'($urandom) : b;
    expect_seq_i <= cur_seq;
    expect_row_i <= cur_row;
    expect_crc_i <= cur_crc;
    expect_pages_i <= cur_pages;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic end_beats();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_bytes(input logic [7:0] buf_b [$]);
    foreach (buf_b[k]) send_beat(CMD_BYTE, buf_b[k]);
  endtask

  task automatic restart();
    send_beat(CMD_RESTART, 8'h00);
    session_live = 0;
  endtask

  // builds a frame; corrupt selects a fault: 0 none, 1 header byte, 2 header crc,
  // 3 body crc, 6 bad size; 4 (echo) is applied by the caller, 5 adds no fault here
  function automatic void build_frame(ref logic [7:0] f [$], input logic [15:0] kind,
      input logic [7:0] nonce [16], input logic [15:0] seq, input logic [31:0] row,
      input logic [7:0] body [$], input int corrupt, input int bad_pos);
    logic [31:0] c, bc;
    logic [15:0] blen;
    f = {};
    blen = 16'(body.size());
    if (corrupt == 6) blen = (kind == KIND_ACK) ? ABORT_BODY : ACK_BODY;
    bc = '1;
    foreach (body[k]) bc = crc_step(bc, body[k]);
    bc = (kind == KIND_HELLO) ? 32'd0 : ~bc;
    if (corrupt == 3) bc ^= 32'h1 << $urandom_range(0, 31);
    for (int k = 0; k < 8; k++) f.push_back(MAGIC[k*8 +: 8]);
    f.push_back(8'd1); f.push_back(8'd0);
    f.push_back(kind[7:0]); f.push_back(kind[15:8]);
    f.push_back(8'd48); f.push_back(8'd0); f.push_back(8'd0); f.push_back(8'd0);
    for (int k = 0; k < 16; k++) f.push_back(nonce[k]);
    f.push_back(seq[7:0]); f.push_back(seq[15:8]);
    f.push_back(blen[7:0]); f.push_back(blen[15:8]);
    for (int k = 0; k < 4; k++) f.push_back(row[k*8 +: 8]);
    for (int k = 0; k < 4; k++) f.push_back(bc[k*8 +: 8]);
    if (corrupt == 1) f[bad_pos] = f[bad_pos] ^ (8'h1 << $urandom_range(0, 7));
    c = '1;
    for (int k = 0; k < 44; k++) c = crc_step(c, f[k]);
    c = ~c;
    if (corrupt == 2) c ^= 32'h1 << $urandom_range(0, 31);
    for (int k = 0; k < 4; k++) f.push_back(c[k*8 +: 8]);
    if (kind != KIND_HELLO && corrupt != 1 && corrupt != 2 && corrupt != 6)
      foreach (body[k]) f.push_back(body[k]);
  endfunction

  task automatic send_hello(input int corrupt, input bit zero_nonce);
    logic [7:0] f [$];
    logic [7:0] nb [$];
    for (int k = 0; k < 16; k++) sess_nonce[k] = zero_nonce ? 8'd0 : 8'($urandom);
    if (!zero_nonce && sess_nonce[0] == 0 && $urandom_range(0, 1)) sess_nonce[15] = 8'h80;
    if (!zero_nonce) sess_nonce[$urandom_range(0, 15)] |= 8'h01;
    build_frame(f, KIND_HELLO, sess_nonce, 16'hffff, 32'hffffffff, nb, corrupt,
                $urandom_range(0, 43));
    send_bytes(f);
    session_live = (corrupt == 0 && !zero_nonce);
  endtask

  task automatic new_expects();
    cur_seq = 16'($urandom); cur_row = $urandom;
    cur_crc = $urandom; cur_pages = $urandom;
  endtask

  task automatic send_ack(input int corrupt);
    logic [7:0] f [$];
    logic [7:0] bd [$];
    for (int k = 0; k < 4; k++) bd.push_back(cur_crc[k*8 +: 8]);
    for (int k = 0; k < 4; k++) bd.push_back(cur_pages[k*8 +: 8]);
    if (corrupt == 4) bd[$urandom_range(0, 7)] ^= 8'h01 << $urandom_range(0, 7);
    build_frame(f, KIND_ACK, sess_nonce, cur_seq, cur_row, bd, corrupt,
                $urandom_range(0, 43));
    send_bytes(f);
    if (corrupt != 0) session_live = 0;
  endtask

  task automatic send_abort(input logic [31:0] reason, input int corrupt);
    logic [7:0] f [$];
    logic [7:0] bd [$];
    for (int k = 0; k < 4; k++) bd.push_back(reason[k*8 +: 8]);
    build_frame(f, KIND_ABORT, sess_nonce, cur_seq, cur_row, bd, corrupt,
                $urandom_range(0, 43));
    send_bytes(f);
    session_live = 0;
  endtask

  task automatic drain();
    end_beats();
    while (verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_hello_and_ack();
    new_expects();
    restart();
    send_hello(0, 0);
    send_ack(0);
    cur_seq = 16'hffff; cur_row = '1; cur_crc = '1; cur_pages = '1;
    send_ack(0);
    cur_seq = 16'h0; cur_row = '0; cur_crc = '0; cur_pages = '0;
    send_ack(0);
  endtask

  task automatic test_aborts();
    for (int r = 0; r <= 5; r++) begin
      new_expects();
      restart(); send_hello(0, 0);
      send_abort((r == 5) ? 32'hffffffff : r, 0);
      send_beat(CMD_BYTE, 8'hff);   // ignored while stopped
    end
  endtask

  task automatic test_faults();
    new_expects();
    restart(); send_hello(0, 1);               // all-zero nonce
    restart(); send_hello(1, 0);
    restart(); send_hello(2, 0);
    for (int c = 1; c <= 6; c++) begin
      restart(); send_hello(0, 0); new_expects();
      if (c == 5) send_abort(32'h100, 0);
      else send_ack(c);
    end
    restart(); send_hello(0, 0);
    send_abort(32'd2, 3);                      // body CRC checked before reason
  endtask

  task automatic test_backpressure();
    restart(); send_hello(0, 0);
    hold_rx = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      begin
        for (int k = 0; k < 4; k++) begin
          new_expects(); send_ack(0);
        end
      end
    join
    drain();
  endtask

  task automatic test_random(input int n_items);
    int sent, pick, r;
    logic [7:0] junk [$];
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (!session_live || pick < 4) begin
        restart(); new_expects();
        r = $urandom_range(0, 19);
        send_hello(r == 0 ? 1 : (r == 1 ? 2 : 0), r == 2);
        sent += 49;
      end else if (pick < 80) begin
        new_expects(); send_ack(0); sent += 56;
      end else if (pick < 88) begin
        new_expects(); send_abort($urandom_range(0, 6), 0); sent += 52;
      end else if (pick < 96) begin
        new_expects(); send_ack($urandom_range(1, 6)); sent += 50;
      end else begin
        junk = {};
        r = $urandom_range(1, 30);
        for (int k = 0; k < r; k++) junk.push_back(8'($urandom));
        send_bytes(junk); sent += r;
        session_live = 0;
      end
      if ($urandom_range(0, 30) == 0) begin
        hold_busy = 1'b1; drain(); hold_busy = 1'b0;
      end
    end
  endtask

  initial begin
    clear_frame();
    pr_phase = PH_HELLO;
    for (int k = 0; k < 16; k++) pr_nonce[k] = '0;
    new_expects();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_hello_and_ack();
    test_aborts();
    test_faults();
    drain();
    test_backpressure();
    test_random(900);
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && verdicts_due.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/rfc_pkg.sv
hdl/rfc_queue.sv
hdl/rfc_back.sv
hdl/rfc_front.sv
hdl/reply_frame_checker_unit.sv
verif/reply_frame_checker_unit_test.sv
